// ===== src/phc_pkg.sv =====
// Shared types and constants of the polygon half-plane clipper.
package phc_pkg;

    localparam int CW   = 24;            // coordinate width
    localparam int XW   = CW + 1;        // coordinate difference
    localparam int PW   = 2 * XW;        // one product of the side test
    localparam int SW   = PW + 1;        // side test value
    localparam int DW   = SW + 1;        // denominator u+v
    localparam int LW   = SW / 2 + 1;    // low slice of a side magnitude
    localparam int HW   = SW - LW;       // high slice
    localparam int PRW  = CW + LW + 1;   // partial product
    localparam int NW   = CW + DW;       // numerator p*v + q*u
    localparam int CNTW = $clog2(CW);    // step counter
    localparam int IDXW = 2;             // register index
    localparam int QD   = 2;             // queue depth
    localparam int QPW  = $clog2(QD);

    localparam logic [IDXW-1:0] REG_AX = 2'd0;
    localparam logic [IDXW-1:0] REG_AY = 2'd1;
    localparam logic [IDXW-1:0] REG_BX = 2'd2;
    localparam logic [IDXW-1:0] REG_BY = 2'd3;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [SW-1:0] t_side;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_line;

    typedef struct packed {
        t_coord px;
        t_coord py;
        t_coord cx;
        t_coord cy;
        t_side  cp;
        t_side  cc;
        logic   have_prev;
        logic   closing;
    } t_entry;

endpackage

// ===== src/phc_vert_if.sv =====
// Vertex input channel.
interface phc_vert_if import phc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord vert_x;
    t_coord vert_y;
    logic   closing;

    modport source (output valid, output vert_x, output vert_y, output closing, input ready);
    modport sink   (input valid, input vert_x, input vert_y, input closing, output ready);
endinterface

// ===== src/phc_res_if.sv =====
// Clipped vertex output channel.
interface phc_res_if import phc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord out_x;
    t_coord out_y;
    logic   is_vertex;
    logic   end_of_polygon;

    modport source (output valid, output out_x, output out_y, output is_vertex,
                    output end_of_polygon, input ready);
    modport sink   (input valid, input out_x, input out_y, input is_vertex,
                    input end_of_polygon, output ready);
endinterface

// ===== src/phc_front.sv =====
// Front end: takes vertices, computes both side tests, queues classified items.
module phc_front import phc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    phc_vert_if.sink i_vert,
    input  t_line  i_line,
    output logic   o_push,
    output t_entry o_entry,
    input  logic   i_push_ready
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0] r_state;
    t_coord r_cx, r_cy, r_px, r_py;
    logic   r_cl, r_hp;
    logic signed [PW-1:0] r_t1c, r_t2c, r_t1p, r_t2p;
    logic signed [XW-1:0] dxc, dyc, dxp, dyp, day, dax;

    assign i_vert.ready = (r_state == F_IDLE);

    always_comb begin
        day = XW'(i_line.ay) - XW'(i_line.by);
        dax = XW'(i_line.ax) - XW'(i_line.bx);
        dxc = XW'(r_cx) - XW'(i_line.bx);
        dyc = XW'(r_cy) - XW'(i_line.by);
        dxp = XW'(r_px) - XW'(i_line.bx);
        dyp = XW'(r_py) - XW'(i_line.by);
    end

    always_comb begin
        o_push            = (r_state == F_PUSH);
        o_entry.px        = r_px;
        o_entry.py        = r_py;
        o_entry.cx        = r_cx;
        o_entry.cy        = r_cy;
        o_entry.cc        = SW'(r_t1c) - SW'(r_t2c);
        o_entry.cp        = SW'(r_t1p) - SW'(r_t2p);
        o_entry.have_prev = r_hp;
        o_entry.closing   = r_cl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_hp    <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_vert.valid) begin
                        r_cx    <= i_vert.vert_x;
                        r_cy    <= i_vert.vert_y;
                        r_cl    <= i_vert.closing;
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_t1c   <= dxc * day;
                    r_t2c   <= dyc * dax;
                    r_t1p   <= dxp * day;
                    r_t2p   <= dyp * dax;
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_push_ready) begin
                        if (r_cl) begin
                            r_hp <= 1'b0;
                        end else begin
                            r_hp <= 1'b1;
                            r_px <= r_cx;
                            r_py <= r_cy;
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== src/phc_queue.sv =====
// Short queue of classified items between front and back.
module phc_queue import phc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_push_ready,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);
    t_entry r_mem [QD];
    logic [QPW-1:0] r_wp, r_rp;
    logic [QPW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_push_ready = (r_cnt != (QPW+1)'(QD));
    assign o_valid      = (r_cnt != '0);
    assign o_entry      = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPW+1)'(QD))
        else $error("queue count beyond depth");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (QPW+1)'(QD)) && !do_pop |=> (r_cnt == (QPW+1)'(QD)))
        else $error("full queue lost an item");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) && !do_push |=> (r_cnt == '0))
        else $error("empty queue gained an item");

endmodule

// ===== src/phc_back.sv =====
// Back end: emits kept vertices, crossings, closing vertex and end markers.
module phc_back import phc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_entry,
    output logic   o_pop,
    phc_res_if.source o_res
);
    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_PREV  = 4'd1;
    localparam logic [3:0] B_MUL   = 4'd2;
    localparam logic [3:0] B_DIV   = 4'd3;
    localparam logic [3:0] B_INT   = 4'd4;
    localparam logic [3:0] B_CLOSE = 4'd5;
    localparam logic [3:0] B_CUR   = 4'd6;
    localparam logic [3:0] B_FIRST = 4'd7;
    localparam logic [3:0] B_MARK  = 4'd8;

    logic [3:0] r_state;
    t_entry r_e;
    logic r_eint, r_ecur, r_n, r_any;
    t_coord r_fx, r_fy, r_lx, r_ly;
    logic [SW-1:0] r_u, r_v;
    logic [DW-1:0] r_den;
    logic [CNTW-1:0] r_cnt;
    logic signed [PRW-1:0] r_prodx, r_prody;
    logic r_phi;
    logic signed [NW-1:0] r_numx, r_numy;
    logic [DW-1:0] r_remx, r_remy;
    logic [CW-1:0] r_lowx, r_lowy;
    logic r_negx, r_negy;
    logic r_ov, r_oisv, r_oend;
    t_coord r_ox, r_oy;

    // head of queue classification
    logic sp_neg, sp_zero, sc_neg, sc_zero, e_prev_n, e_int_n, e_cur_n;
    logic [SW-1:0] u_n, v_n;
    // multiplier
    t_coord mx, my;
    logic [SW-1:0] mg;
    logic [LW:0] half;
    logic signed [PRW-1:0] prodx, prody;
    logic signed [NW-1:0] magx, magy;
    // divider
    logic [DW:0] trx, try_;
    logic gex, gey, rndx, rndy;
    logic [CW:0] q1x, q1y, qnx, qny;
    t_coord ix, iy;
    // emission
    logic em_valid, em_isv, em_end, em_need, em_go, out_free;
    t_coord em_x, em_y;

    always_comb begin
        sp_neg   = i_entry.cp[SW-1];
        sp_zero  = (i_entry.cp == '0);
        sc_neg   = i_entry.cc[SW-1];
        sc_zero  = (i_entry.cc == '0);
        e_prev_n = i_entry.have_prev && !sp_neg;
        e_int_n  = i_entry.have_prev && ((!sp_neg && !sp_zero && sc_neg) ||
                                         (sp_neg && !sc_neg && !sc_zero));
        e_cur_n  = i_entry.closing && !sc_neg;
        u_n      = sp_neg ? SW'(-i_entry.cp) : SW'(i_entry.cp);
        v_n      = sc_neg ? SW'(-i_entry.cc) : SW'(i_entry.cc);
    end

    always_comb begin
        mx    = r_cnt[1] ? r_e.cx : r_e.px;
        my    = r_cnt[1] ? r_e.cy : r_e.py;
        mg    = r_cnt[1] ? r_u : r_v;
        half  = r_cnt[0] ? (LW+1)'(mg[SW-1:LW]) : {1'b0, mg[LW-1:0]};
        prodx = mx * $signed(half);
        prody = my * $signed(half);
        magx  = r_numx[NW-1] ? -r_numx : r_numx;
        magy  = r_numy[NW-1] ? -r_numy : r_numy;
    end

    always_comb begin
        trx  = {r_remx, r_lowx[CW-1]};
        try_ = {r_remy, r_lowy[CW-1]};
        gex  = (trx >= {1'b0, r_den});
        gey  = (try_ >= {1'b0, r_den});
        rndx = (r_remx >= (r_den - r_remx));
        rndy = (r_remy >= (r_den - r_remy));
        q1x  = {1'b0, r_lowx} + (CW+1)'(rndx);
        q1y  = {1'b0, r_lowy} + (CW+1)'(rndy);
        qnx  = (CW+1)'(0) - q1x;
        qny  = (CW+1)'(0) - q1y;
        ix   = r_negx ? qnx[CW-1:0] : q1x[CW-1:0];
        iy   = r_negy ? qny[CW-1:0] : q1y[CW-1:0];
    end

    always_comb begin
        em_valid = 1'b0;
        em_isv   = 1'b1;
        em_x     = r_e.cx;
        em_y     = r_e.cy;
        case (r_state)
            B_PREV: begin
                em_valid = 1'b1;
                em_x     = r_e.px;
                em_y     = r_e.py;
            end
            B_INT: begin
                em_valid = 1'b1;
                em_x     = ix;
                em_y     = iy;
            end
            B_CUR:   em_valid = 1'b1;
            B_FIRST: begin
                em_valid = 1'b1;
                em_x     = r_fx;
                em_y     = r_fy;
            end
            B_MARK: begin
                em_valid = 1'b1;
                em_isv   = 1'b0;
                em_x     = '0;
                em_y     = '0;
            end
            default: em_valid = 1'b0;
        endcase
        em_need = r_any && ((r_fx != em_x) || (r_fy != em_y));
        case (r_state)
            B_PREV:  em_end = r_e.closing && !r_eint && !r_ecur && !em_need;
            B_INT:   em_end = r_e.closing && !r_ecur && !em_need;
            B_CUR:   em_end = !em_need;
            default: em_end = 1'b1;
        endcase
        out_free = !r_ov || o_res.ready;
        em_go    = em_valid && out_free;
    end

    assign o_pop            = (r_state == B_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.out_x      = r_ox;
    assign o_res.out_y      = r_oy;
    assign o_res.is_vertex  = r_oisv;
    assign o_res.end_of_polygon = r_oend;

    always_ff @(posedge i_clk) begin
        if (em_go) begin
            r_ox   <= em_x;
            r_oy   <= em_y;
            r_oisv <= em_isv;
            r_oend <= em_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
            r_any   <= 1'b0;
            r_n     <= 1'b0;
            r_fx    <= '0;
            r_fy    <= '0;
            r_lx    <= '0;
            r_ly    <= '0;
        end else begin
            if (em_go) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (em_go && em_isv) begin
                if (!r_any) begin
                    r_fx <= em_x;
                    r_fy <= em_y;
                end
                r_lx  <= em_x;
                r_ly  <= em_y;
                r_any <= 1'b1;
                r_n   <= 1'b1;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_e    <= i_entry;
                        r_eint <= e_int_n;
                        r_ecur <= e_cur_n;
                        r_u    <= u_n;
                        r_v    <= v_n;
                        r_den  <= DW'(u_n) + DW'(v_n);
                        r_n    <= 1'b0;
                        r_cnt  <= '0;
                        if (e_prev_n) begin
                            r_state <= B_PREV;
                        end else if (e_int_n) begin
                            r_state <= B_MUL;
                        end else if (i_entry.closing) begin
                            r_state <= B_CLOSE;
                        end
                    end
                end
                B_PREV: begin
                    if (em_go) begin
                        if (r_eint) begin
                            r_state <= B_MUL;
                        end else if (r_e.closing) begin
                            r_state <= B_CLOSE;
                        end else begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                B_MUL: begin
                    r_prodx <= prodx;
                    r_prody <= prody;
                    r_phi   <= r_cnt[0];
                    if (r_cnt == '0) begin
                        r_numx <= '0;
                        r_numy <= '0;
                    end else begin
                        r_numx <= r_numx + (r_phi ? (NW'(r_prodx) <<< LW) : NW'(r_prodx));
                        r_numy <= r_numy + (r_phi ? (NW'(r_prody) <<< LW) : NW'(r_prody));
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(5)) begin
                        r_negx  <= r_numx[NW-1];
                        r_negy  <= r_numy[NW-1];
                        r_remx  <= magx[NW-1:CW];
                        r_remy  <= magy[NW-1:CW];
                        r_lowx  <= magx[CW-1:0];
                        r_lowy  <= magy[CW-1:0];
                        r_cnt   <= '0;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_remx <= gex ? DW'(trx - {1'b0, r_den}) : trx[DW-1:0];
                    r_remy <= gey ? DW'(try_ - {1'b0, r_den}) : try_[DW-1:0];
                    r_lowx <= {r_lowx[CW-2:0], gex};
                    r_lowy <= {r_lowy[CW-2:0], gey};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(CW - 1)) begin
                        r_state <= B_INT;
                    end
                end
                B_INT: begin
                    if (em_go) begin
                        r_state <= r_e.closing ? B_CLOSE : B_IDLE;
                    end
                end
                B_CLOSE: begin
                    if (r_ecur) begin
                        r_state <= B_CUR;
                    end else if (r_any && ((r_fx != r_lx) || (r_fy != r_ly))) begin
                        r_state <= B_FIRST;
                    end else if (!r_n) begin
                        r_state <= B_MARK;
                    end else begin
                        r_any   <= 1'b0;
                        r_state <= B_IDLE;
                    end
                end
                B_CUR: begin
                    if (em_go) begin
                        if (em_need) begin
                            r_state <= B_FIRST;
                        end else begin
                            r_any   <= 1'b0;
                            r_state <= B_IDLE;
                        end
                    end
                end
                B_FIRST, B_MARK: begin
                    if (em_go) begin
                        r_any   <= 1'b0;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_den != '0))
        else $error("crossing with zero denominator");

    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MARK) |-> (!r_n && r_e.closing))
        else $error("end marker after emitted vertices");

    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FIRST) |-> (r_any && r_e.closing))
        else $error("closing vertex without an earlier vertex");

endmodule

// ===== src/polygon_halfplane_clip_top.sv =====
// Top level of the polygon half-plane clipper.
//
// Clips a closed polygon against the half-plane left of the line a->b.
// Line registers (ax, ay, bx, by, signed Q16.8) are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while
// the block is idle, as the block itself has no guard for this. Vertices
// arrive on i_vert, one item each; the item flagged closing repeats the
// first vertex and ends the polygon. Results leave on o_res: kept vertices,
// edge crossings, the closing vertex, and an end marker (is_vertex low)
// when a closing item has no result of its own. end_of_polygon marks the
// last result of a polygon. The front takes an item, forms the products
// of both side tests and pushes it into a 2-deep queue, taking no new item
// until that push is done. The back takes an item, emits its results one
// at a time, gives a closing item a closing step, and for an edge crossing
// runs a multiply-accumulate and a bit-serial division. Reset clears line
// registers, polygon state and the queue. A stalled receiver holds the
// output register; the back waits, the queue fills and then the front
// stops taking items.
module polygon_halfplane_clip_top import phc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    phc_vert_if.sink        i_vert,
    phc_res_if.source       o_res,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_idx,
    input  logic [CW-1:0]   i_cfg_data
);
    t_line  r_line;
    logic   push, push_ready, q_valid, pop;
    t_entry f_entry, q_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AX:  r_line.ax <= i_cfg_data;
                REG_AY:  r_line.ay <= i_cfg_data;
                REG_BX:  r_line.bx <= i_cfg_data;
                REG_BY:  r_line.by <= i_cfg_data;
                default: r_line    <= r_line;
            endcase
        end
    end

    phc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vert       (i_vert),
        .i_line       (r_line),
        .o_push       (push),
        .o_entry      (f_entry),
        .i_push_ready (push_ready)
    );

    phc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (f_entry),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_entry      (q_entry),
        .i_pop        (pop)
    );

    phc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
